// ----- hdl/rsq_pkg.sv -----
// Run queue scheduler package: request and status codes, controller states,
// and the command and flag bundles between controller and datapath.
// Used by rsq_ctrl, rsq_dp and active_expired_run_queue_scheduler.
package rsq_pkg;

	localparam int TID_W   = 8;
	localparam int SLICE_W = 24;
	localparam logic [SLICE_W-1:0] SLICE_RESET = 24'd10000;

	typedef enum logic [1:0] {
		REQ_ENQ   = 2'd0,
		REQ_ERASE = 2'd1,
		REQ_SCHED = 2'd2,
		REQ_LEAVE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SRC_TID  = 2'd0,
		SRC_CUR  = 2'd1,
		SRC_NEXT = 2'd2
	} src_t;

	typedef enum logic [1:0] {
		RD_BACK = 2'd0,
		RD_IDX  = 2'd1,
		RD_IDX1 = 2'd2,
		RD_HEAD = 2'd3
	} rd_kind_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_ENQ,
		S_LEAVE,
		S_ER_START,
		S_ER_BACK,
		S_SC_RD,
		S_SC_CMP,
		S_SH_RD,
		S_SH_WR,
		S_SCHED,
		S_CHG,
		S_PICK,
		S_POP,
		S_COMMIT,
		S_COMMIT_CUR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic     load;
		logic     slice_fresh;
		logic     slice_rd;
		logic     slice_upd;
		logic     push;
		logic     push_exp;
		src_t     push_src;
		logic     push_at_head;
		logic     rd;
		rd_kind_t rd_kind;
		logic     er_first;
		logic     er_second;
		logic     idx_zero;
		logic     idx_back;
		logic     idx_inc;
		logic     sh_wr;
		logic     er_dec;
		logic     pop;
		logic     swap;
		logic     set_next_cur;
		logic     set_next_rd;
		logic     clr_present;
		logic     set_current;
		logic     set_nf;
		logic     set_yield;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic boost;
		logic reset_slice;
		logic blocked;
		logic aboost;
		logic commit;
		logic in_range;
		logic present;
		logic cur_eq_tid;
		logic er_empty;
		logic er_sel;
		logic idx_last;
		logic match;
		logic slice_exp;
		logic act_empty;
		logic exp_empty;
	} flags_t;

endpackage

// ----- hdl/active_expired_run_queue_scheduler.sv -----
// Top level of the active/expired run queue scheduler.
// Instantiates rsq_ctrl and rsq_dp; uses rsq_pkg.

// One request is worked at a time. Enqueue and leave-cpu pass through the
// dispatch state, one work state and the done state; schedule may add slice
// charging, a pick, a pop and a commit; erase walks the deque with a read and
// a compare state per entry for the search and a read and a write state per
// entry for the compaction, since the deque memory has one read and one write port with
// registered read data. The result sits in an output register, so the next
// request is taken while the previous result waits. slice_ticks resets to
// 10000; the deques and per-task slices need no clearing pass after reset.
module active_expired_run_queue_scheduler #(
	parameter int QUEUE_DEPTH = 64,
	parameter int NUM_TASKS   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  task_id,
	input  logic        boost,
	input  logic        reset_slice,
	input  logic        goes_blocked,
	input  logic [23:0] elapsed_ticks,
	input  logic        agent_boost,
	input  logic        commit_ok,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  picked_task,
	output logic        picked_valid,
	output logic        yield_on_idle,
	output logic [1:0]  status,
	output logic        current_valid
);

	rsq_pkg::cmd_t   cmd;
	rsq_pkg::flags_t flags;

	// sequencer
	rsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// queues, slices and result registers
	rsq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_TASKS   (NUM_TASKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req_type),
		.task_id       (task_id),
		.boost         (boost),
		.reset_slice   (reset_slice),
		.goes_blocked  (goes_blocked),
		.elapsed_ticks (elapsed_ticks),
		.agent_boost   (agent_boost),
		.commit_ok     (commit_ok),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.flags         (flags),
		.picked_task   (picked_task),
		.picked_valid  (picked_valid),
		.yield_on_idle (yield_on_idle),
		.status        (status),
		.current_valid (current_valid)
	);

endmodule

// ----- hdl/rsq_ctrl.sv -----
// Run queue scheduler controller: sequences each request over the datapath
// and owns the handshake state. Depends on rsq_pkg.
module rsq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  rsq_pkg::flags_t flags,
	output rsq_pkg::cmd_t   cmd
);

	rsq_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;

	// state and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == rsq_pkg::S_IDLE);

	// next state and datapath commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			rsq_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = rsq_pkg::S_DISPATCH;
				end
			end
			rsq_pkg::S_DISPATCH: begin
				case (flags.req)
					rsq_pkg::REQ_ENQ:   state_nxt = rsq_pkg::S_ENQ;
					rsq_pkg::REQ_ERASE: begin
						cmd.er_first = 1'b1;
						state_nxt    = rsq_pkg::S_ER_START;
					end
					rsq_pkg::REQ_SCHED: state_nxt = rsq_pkg::S_SCHED;
					default:            state_nxt = rsq_pkg::S_LEAVE;
				endcase
			end
			rsq_pkg::S_ENQ: begin
				if (flags.in_range) begin
					cmd.slice_fresh  = flags.reset_slice;
					cmd.push         = 1'b1;
					cmd.push_src     = rsq_pkg::SRC_TID;
					cmd.push_at_head = flags.boost;
				end else begin
					cmd.set_nf = 1'b1;
				end
				state_nxt = rsq_pkg::S_DONE;
			end
			rsq_pkg::S_LEAVE: begin
				if (flags.present && flags.cur_eq_tid) begin
					cmd.clr_present  = 1'b1;
					cmd.push         = !flags.blocked;
					cmd.push_src     = rsq_pkg::SRC_TID;
					cmd.push_at_head = flags.boost;
				end else begin
					cmd.set_nf = 1'b1;
				end
				state_nxt = rsq_pkg::S_DONE;
			end
			rsq_pkg::S_ER_START: begin
				if (flags.er_empty) begin
					if (!flags.er_sel) begin
						cmd.er_second = 1'b1;
					end else begin
						cmd.set_nf = 1'b1;
						state_nxt  = rsq_pkg::S_DONE;
					end
				end else begin
					cmd.rd      = 1'b1;
					cmd.rd_kind = rsq_pkg::RD_BACK;
					state_nxt   = rsq_pkg::S_ER_BACK;
				end
			end
			rsq_pkg::S_ER_BACK: begin
				if (flags.match) begin
					cmd.idx_back = 1'b1;
					state_nxt    = rsq_pkg::S_SH_RD;
				end else begin
					cmd.idx_zero = 1'b1;
					state_nxt    = rsq_pkg::S_SC_RD;
				end
			end
			rsq_pkg::S_SC_RD: begin
				if (flags.idx_last) begin
					if (!flags.er_sel) begin
						cmd.er_second = 1'b1;
						state_nxt     = rsq_pkg::S_ER_START;
					end else begin
						cmd.set_nf = 1'b1;
						state_nxt  = rsq_pkg::S_DONE;
					end
				end else begin
					cmd.rd      = 1'b1;
					cmd.rd_kind = rsq_pkg::RD_IDX;
					state_nxt   = rsq_pkg::S_SC_CMP;
				end
			end
			rsq_pkg::S_SC_CMP: begin
				if (flags.match) begin
					state_nxt = rsq_pkg::S_SH_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = rsq_pkg::S_SC_RD;
				end
			end
			rsq_pkg::S_SH_RD: begin
				if (flags.idx_last) begin
					cmd.er_dec = 1'b1;
					state_nxt  = rsq_pkg::S_DONE;
				end else begin
					cmd.rd      = 1'b1;
					cmd.rd_kind = rsq_pkg::RD_IDX1;
					state_nxt   = rsq_pkg::S_SH_WR;
				end
			end
			rsq_pkg::S_SH_WR: begin
				cmd.sh_wr   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_nxt   = rsq_pkg::S_SH_RD;
			end
			rsq_pkg::S_SCHED: begin
				if (flags.aboost) begin
					cmd.set_yield = 1'b1;
					state_nxt     = rsq_pkg::S_DONE;
				end else if (flags.present) begin
					cmd.slice_rd = 1'b1;
					state_nxt    = rsq_pkg::S_CHG;
				end else begin
					state_nxt = rsq_pkg::S_PICK;
				end
			end
			rsq_pkg::S_CHG: begin
				// charge ticks; an exhausted task moves to the expired deque
				cmd.slice_upd = 1'b1;
				if (flags.slice_exp) begin
					cmd.clr_present = 1'b1;
					cmd.push        = 1'b1;
					cmd.push_exp    = 1'b1;
					cmd.push_src    = rsq_pkg::SRC_CUR;
					state_nxt       = rsq_pkg::S_PICK;
				end else begin
					cmd.set_next_cur = 1'b1;
					state_nxt        = rsq_pkg::S_COMMIT_CUR;
				end
			end
			rsq_pkg::S_PICK: begin
				if (flags.act_empty) begin
					if (!flags.exp_empty)
						cmd.swap = 1'b1;
					else
						state_nxt = rsq_pkg::S_DONE;
				end else begin
					cmd.rd      = 1'b1;
					cmd.rd_kind = rsq_pkg::RD_HEAD;
					state_nxt   = rsq_pkg::S_POP;
				end
			end
			rsq_pkg::S_POP: begin
				cmd.set_next_rd = 1'b1;
				cmd.pop         = 1'b1;
				state_nxt       = rsq_pkg::S_COMMIT;
			end
			rsq_pkg::S_COMMIT, rsq_pkg::S_COMMIT_CUR: begin
				if (flags.commit) begin
					cmd.set_current = 1'b1;
				end else begin
					cmd.clr_present  = (state_q == rsq_pkg::S_COMMIT_CUR);
					cmd.push         = 1'b1;
					cmd.push_src     = rsq_pkg::SRC_NEXT;
					cmd.push_at_head = 1'b1;
				end
				state_nxt = rsq_pkg::S_DONE;
			end
			rsq_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = rsq_pkg::S_IDLE;
				end
			end
			default: state_nxt = rsq_pkg::S_IDLE;
		endcase
	end

endmodule

// ----- hdl/rsq_dp.sv -----
// Run queue scheduler datapath: deque memory, slice memory, counts, heads,
// current task and result registers. Depends on rsq_pkg; driven by rsq_ctrl.
module rsq_dp #(
	parameter int QUEUE_DEPTH = 64,
	parameter int NUM_TASKS   = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  req_type,
	input  logic [rsq_pkg::TID_W-1:0]   task_id,
	input  logic                        boost,
	input  logic                        reset_slice,
	input  logic                        goes_blocked,
	input  logic [rsq_pkg::SLICE_W-1:0] elapsed_ticks,
	input  logic                        agent_boost,
	input  logic                        commit_ok,
	input  logic                        cfg_we,
	input  logic [rsq_pkg::SLICE_W-1:0] cfg_wdata,
	input  rsq_pkg::cmd_t               cmd,
	output rsq_pkg::flags_t             flags,
	output logic [rsq_pkg::TID_W-1:0]   picked_task,
	output logic                        picked_valid,
	output logic                        yield_on_idle,
	output logic [1:0]                  status,
	output logic                        current_valid
);

	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int AW  = $clog2(2 * QUEUE_DEPTH);
	localparam int SAW = $clog2(NUM_TASKS);
	localparam int TW  = rsq_pkg::TID_W;
	localparam int SW  = rsq_pkg::SLICE_W;
	localparam logic [CW:0]   QD_W   = (CW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] QD_C   = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] QD_TOP = PW'(QUEUE_DEPTH - 1);

	// head plus offset around the ring
	function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] base, logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW + 1)'(base) + (CW + 1)'(off);
		if (s >= QD_W)
			s = s - QD_W;
		return s[PW-1:0];
	endfunction

	// physical bank plus ring position to memory address
	function automatic logic [AW-1:0] bank_addr(logic b, logic [PW-1:0] p);
		return b ? (AW'(p) + AW'(QUEUE_DEPTH)) : AW'(p);
	endfunction

	logic [SW-1:0]    slice_ticks_q;
	rsq_pkg::req_t    req_q;
	logic [TW-1:0]    tid_q;
	logic             boost_q, rs_q, blk_q, aboost_q, commit_q;
	logic [SW-1:0]    elapsed_q;
	logic             act_q;
	logic [PW-1:0]    head_q [2];
	logic [CW-1:0]    cnt_q  [2];
	logic [TW-1:0]    cur_q, next_q;
	logic             present_q, er_sel_q;
	logic [CW-1:0]    idx_q;
	rsq_pkg::status_t status_q;
	logic             pvalid_q, yidle_q;
	logic [TW-1:0]    picked_q;
	logic [TW-1:0]    out_picked_q;
	logic             out_pvalid_q, out_yidle_q, out_cv_q;
	logic [1:0]       out_status_q;

	logic [TW-1:0]    dq_mem [2 * QUEUE_DEPTH];
	logic [TW-1:0]    dq_rdata_q;
	logic [SW-1:0]    slice_mem [NUM_TASKS];
	logic [SW-1:0]    slice_rdata_q;

	logic             act_b, exp_b, er_b, push_b, push_full, push_ok;
	logic [CW-1:0]    push_cnt, er_cnt;
	logic [PW-1:0]    push_head, er_head, push_ptr;
	logic [TW-1:0]    push_id;
	logic             dq_we;
	logic [AW-1:0]    dq_waddr, dq_raddr;
	logic [TW-1:0]    dq_wdata;
	logic [31:0]      tid_ext, cur_ext;
	logic [SAW-1:0]   tid_addr, cur_addr;
	logic             slice_exp, sl_we;
	logic [SAW-1:0]   sl_waddr;
	logic [SW-1:0]    sl_wdata;

	// bank selection and deque pointers
	always_comb begin
		act_b     = act_q;
		exp_b     = ~act_q;
		er_b      = act_q ^ er_sel_q;
		push_b    = cmd.push_exp ? exp_b : act_b;
		push_cnt  = cnt_q[push_b];
		push_head = head_q[push_b];
		er_cnt    = cnt_q[er_b];
		er_head   = head_q[er_b];
		push_full = (push_cnt >= QD_C);
		push_ok   = cmd.push && !push_full;
		if (cmd.push_at_head)
			push_ptr = (push_head == '0) ? QD_TOP : (push_head - PW'(1));
		else
			push_ptr = wrap_add(push_head, push_cnt);
		case (cmd.push_src)
			rsq_pkg::SRC_CUR:  push_id = cur_q;
			rsq_pkg::SRC_NEXT: push_id = next_q;
			default:           push_id = tid_q;
		endcase
		dq_we = push_ok || cmd.sh_wr;
		if (cmd.sh_wr) begin
			dq_waddr = bank_addr(er_b, wrap_add(er_head, idx_q));
			dq_wdata = dq_rdata_q;
		end else begin
			dq_waddr = bank_addr(push_b, push_ptr);
			dq_wdata = push_id;
		end
		case (cmd.rd_kind)
			rsq_pkg::RD_BACK: dq_raddr = bank_addr(er_b, wrap_add(er_head, er_cnt - CW'(1)));
			rsq_pkg::RD_IDX:  dq_raddr = bank_addr(er_b, wrap_add(er_head, idx_q));
			rsq_pkg::RD_IDX1: dq_raddr = bank_addr(er_b, wrap_add(er_head, idx_q + CW'(1)));
			default:          dq_raddr = bank_addr(act_b, head_q[act_b]);
		endcase
	end

	// slice memory addressing and update value
	always_comb begin
		tid_ext   = 32'(tid_q);
		cur_ext   = 32'(cur_q);
		tid_addr  = tid_ext[SAW-1:0];
		cur_addr  = cur_ext[SAW-1:0];
		slice_exp = (slice_rdata_q <= elapsed_q);
		sl_we     = cmd.slice_fresh || cmd.slice_upd;
		sl_waddr  = cmd.slice_fresh ? tid_addr : cur_addr;
		sl_wdata  = (cmd.slice_fresh || slice_exp) ? slice_ticks_q
		                                           : (slice_rdata_q - elapsed_q);
	end

	// deque and slice memories
	always_ff @(posedge clk) begin
		if (dq_we)
			dq_mem[dq_waddr] <= dq_wdata;
		if (cmd.rd)
			dq_rdata_q <= dq_mem[dq_raddr];
		if (sl_we)
			slice_mem[sl_waddr] <= sl_wdata;
		if (cmd.slice_rd)
			slice_rdata_q <= slice_mem[cur_addr];
	end

	// capture the request beat and the result beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= rsq_pkg::req_t'(req_type);
			tid_q     <= task_id;
			boost_q   <= boost;
			rs_q      <= reset_slice;
			blk_q     <= goes_blocked;
			elapsed_q <= elapsed_ticks;
			aboost_q  <= agent_boost;
			commit_q  <= commit_ok;
		end
		if (cmd.set_next_cur)
			next_q <= cur_q;
		else if (cmd.set_next_rd)
			next_q <= dq_rdata_q;
		if (cmd.out_load) begin
			out_picked_q <= picked_q;
			out_pvalid_q <= pvalid_q;
			out_yidle_q  <= yidle_q;
			out_status_q <= status_q;
			out_cv_q     <= present_q;
		end
	end

	// control state: counts, heads, roles, current task, scan index, status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_ticks_q <= rsq_pkg::SLICE_RESET;
			act_q         <= 1'b0;
			head_q[0]     <= '0;
			head_q[1]     <= '0;
			cnt_q[0]      <= '0;
			cnt_q[1]      <= '0;
			cur_q         <= '0;
			present_q     <= 1'b0;
			er_sel_q      <= 1'b0;
			idx_q         <= '0;
			status_q      <= rsq_pkg::ST_OK;
			pvalid_q      <= 1'b0;
			yidle_q       <= 1'b0;
			picked_q      <= '0;
		end else begin
			if (cfg_we)
				slice_ticks_q <= cfg_wdata;
			if (cmd.load) begin
				status_q <= rsq_pkg::ST_OK;
				pvalid_q <= 1'b0;
				yidle_q  <= 1'b0;
				picked_q <= '0;
			end
			if (cmd.push && push_full)
				status_q <= rsq_pkg::ST_FULL;
			if (cmd.set_nf)
				status_q <= rsq_pkg::ST_NOTFOUND;
			if (push_ok) begin
				cnt_q[push_b] <= push_cnt + CW'(1);
				if (cmd.push_at_head)
					head_q[push_b] <= push_ptr;
			end
			if (cmd.pop) begin
				cnt_q[act_b]  <= cnt_q[act_b] - CW'(1);
				head_q[act_b] <= wrap_add(head_q[act_b], CW'(1));
			end
			if (cmd.er_dec)
				cnt_q[er_b] <= er_cnt - CW'(1);
			if (cmd.swap)
				act_q <= ~act_q;
			if (cmd.er_first)
				er_sel_q <= 1'b0;
			else if (cmd.er_second)
				er_sel_q <= 1'b1;
			if (cmd.idx_zero)
				idx_q <= '0;
			else if (cmd.idx_back)
				idx_q <= er_cnt - CW'(1);
			else if (cmd.idx_inc)
				idx_q <= idx_q + CW'(1);
			if (cmd.set_yield)
				yidle_q <= present_q || (cnt_q[0] != '0) || (cnt_q[1] != '0);
			if (cmd.clr_present)
				present_q <= 1'b0;
			else if (cmd.set_current) begin
				present_q <= 1'b1;
				cur_q     <= next_q;
				picked_q  <= next_q;
				pvalid_q  <= 1'b1;
			end
		end
	end

	// status toward the controller
	always_comb begin
		flags.req         = req_q;
		flags.boost       = boost_q;
		flags.reset_slice = rs_q;
		flags.blocked     = blk_q;
		flags.aboost      = aboost_q;
		flags.commit      = commit_q;
		flags.in_range    = (tid_ext < 32'(NUM_TASKS));
		flags.present     = present_q;
		flags.cur_eq_tid  = (cur_q == tid_q);
		flags.er_empty    = (er_cnt == '0);
		flags.er_sel      = er_sel_q;
		flags.idx_last    = ((CW + 1)'(idx_q) + (CW + 1)'(1)) >= (CW + 1)'(er_cnt);
		flags.match       = (dq_rdata_q == tid_q);
		flags.slice_exp   = slice_exp;
		flags.act_empty   = (cnt_q[act_b] == '0);
		flags.exp_empty   = (cnt_q[exp_b] == '0);
	end

	assign picked_task   = out_picked_q;
	assign picked_valid  = out_pvalid_q;
	assign yield_on_idle = out_yidle_q;
	assign status        = out_status_q;
	assign current_valid = out_cv_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= QD_C) && (cnt_q[1] <= QD_C))
		else $error("deque count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (cnt_q[act_b] != '0))
		else $error("pop from empty active deque");
	a_shift_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sh_wr |-> (((CW + 1)'(idx_q) + (CW + 1)'(1)) < (CW + 1)'(er_cnt)))
		else $error("compaction past the deque end");
	a_commit_cur: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_current |=> (present_q && (cur_q == $past(next_q))))
		else $error("commit did not place the picked task");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for active_expired_run_queue_scheduler: directed and random run-queue
// traffic, checked against an in-bench predictor of the deques, slices and current task.
// Depends on rsq_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb;

	localparam int QDEPTH   = 64;
	localparam int LIMIT    = 2000000;
	localparam int HOLD_LEN = 300;

	typedef struct {
		bit [7:0]         picked;
		bit               pvalid;
		bit               yield;
		rsq_pkg::status_t st;
		bit               curv;
	} sched_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [23:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [7:0]  task_id;
	logic        boost;
	logic        reset_slice;
	logic        goes_blocked;
	logic [23:0] elapsed_ticks;
	logic        agent_boost;
	logic        commit_ok;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  picked_task;
	logic        picked_valid;
	logic        yield_on_idle;
	logic [1:0]  status;
	logic        current_valid;

	// predictor state
	bit [7:0]      act_q[$];
	bit [7:0]      exp_q[$];
	int            slice_left[256];
	bit            slice_set[256];
	bit [23:0]     slice_ticks;
	bit [7:0]      cur_tid;
	bit            cur_present;
	sched_result_t pending_results[$];

	int  errors;
	int  cycles;
	bit  no_idle;
	int  stall_req_n;
	int  stall_done_n;
	int  hold_cnt;

	active_expired_run_queue_scheduler dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.task_id(task_id), .boost(boost), .reset_slice(reset_slice),
		.goes_blocked(goes_blocked), .elapsed_ticks(elapsed_ticks),
		.agent_boost(agent_boost), .commit_ok(commit_ok),
		.out_valid(out_valid), .out_ready(out_ready), .picked_task(picked_task),
		.picked_valid(picked_valid), .yield_on_idle(yield_on_idle),
		.status(status), .current_valid(current_valid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// insert into the active (expired=0) or expired deque
	function automatic bit queue_push(bit expired, bit [7:0] id, bit front);
		if (expired) begin
			if (exp_q.size() >= QDEPTH) return 0;
			if (front) exp_q = {id, exp_q}; else exp_q = {exp_q, id};
		end else begin
			if (act_q.size() >= QDEPTH) return 0;
			if (front) act_q = {id, act_q}; else act_q = {act_q, id};
		end
		return 1;
	endfunction

	// remove one entry: back entry first, then the first match from the front
	function automatic bit queue_erase(ref bit [7:0] q[$], input bit [7:0] id);
		int n;
		int pos;
		n = q.size();
		pos = n;
		if (n == 0) return 0;
		if (q[n-1] == id) pos = n - 1;
		else begin
			for (int i = 0; i + 1 < n; i++) begin
				if (q[i] == id) begin
					pos = i;
					break;
				end
			end
		end
		if (pos >= n) return 0;
		q.delete(pos);
		return 1;
	endfunction

	// advance the predicted run queue by one request and return its result beat
	function automatic sched_result_t run_queue_step(rsq_pkg::req_t r, bit [7:0] tid,
			bit bst, bit rs, bit blk, bit [23:0] el, bit ab, bit cm);
		sched_result_t res;
		bit            have;
		bit            from_cur;
		bit [7:0]      nxt;
		longint        rem;
		bit [7:0]      swp[$];
		res = '{8'd0, 1'b0, 1'b0, rsq_pkg::ST_OK, 1'b0};
		have = 0;
		from_cur = 0;
		nxt = 0;
		case (r)
			rsq_pkg::REQ_ENQ: begin
				if (rs) begin
					slice_left[tid] = int'(slice_ticks);
					slice_set[tid] = 1;
				end
				if (!queue_push(0, tid, bst)) res.st = rsq_pkg::ST_FULL;
			end
			rsq_pkg::REQ_ERASE: begin
				if (!queue_erase(act_q, tid) && !queue_erase(exp_q, tid))
					res.st = rsq_pkg::ST_NOTFOUND;
			end
			rsq_pkg::REQ_SCHED: begin
				if (!ab) begin
					// charge the current task, expire it when its slice runs out
					if (cur_present) begin
						rem = longint'(slice_left[cur_tid]) - longint'(el);
						if (rem <= 0) begin
							slice_left[cur_tid] = int'(slice_ticks);
							cur_present = 0;
							if (!queue_push(1, cur_tid, 0)) res.st = rsq_pkg::ST_FULL;
						end else begin
							slice_left[cur_tid] = int'(rem);
							nxt = cur_tid;
							have = 1;
							from_cur = 1;
						end
					end
					if (!have) begin
						if (act_q.size() == 0 && exp_q.size() != 0) begin
							swp = act_q;
							act_q = exp_q;
							exp_q = swp;
						end
						if (act_q.size() != 0) begin
							nxt = act_q[0];
							act_q.delete(0);
							have = 1;
						end
					end
				end
				if (have) begin
					if (cm) begin
						cur_tid = nxt;
						cur_present = 1;
						res.picked = nxt;
						res.pvalid = 1;
					end else begin
						if (from_cur) cur_present = 0;
						if (!queue_push(0, nxt, 1)) res.st = rsq_pkg::ST_FULL;
					end
				end else begin
					res.yield = ab && (cur_present || act_q.size() != 0 || exp_q.size() != 0);
				end
			end
			default: begin
				if (cur_present && cur_tid == tid) begin
					cur_present = 0;
					if (!blk && !queue_push(0, tid, bst)) res.st = rsq_pkg::ST_FULL;
				end else begin
					res.st = rsq_pkg::ST_NOTFOUND;
				end
			end
		endcase
		res.curv = cur_present;
		return res;
	endfunction

	// offer one request beat, predict it on acceptance, then maybe idle
	task automatic send_req(rsq_pkg::req_t r, bit [7:0] tid, bit bst, bit rs, bit blk,
			bit [23:0] el, bit ab, bit cm);
		// never let the block charge a task whose slice was never set
		if (r == rsq_pkg::REQ_ENQ && !slice_set[tid]) rs = 1;
		in_valid      <= 1'b1;
		req_type      <= r;
		task_id       <= tid;
		boost         <= bst;
		reset_slice   <= rs;
		goes_blocked  <= blk;
		elapsed_ticks <= el;
		agent_boost   <= ab;
		commit_ok     <= cm;
		do @(posedge clk); while (!in_ready);
		pending_results = {pending_results, run_queue_step(r, tid, bst, rs, blk, el, ab, cm)};
		if (!no_idle && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// stop offering and wait for every predicted beat
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_slice(bit [23:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		slice_ticks = v;
	endtask

	function automatic bit [7:0] pick_tid;
		return ($urandom_range(99) < 85) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
	endfunction

	function automatic bit [23:0] pick_elapsed;
		int k;
		k = $urandom_range(9);
		if (k < 2) return 24'd0;
		if (k < 8) return 24'($urandom_range(0, 20000));
		if (k == 8) return 24'hFFFFFF;
		return 24'($urandom);
	endfunction

	// mostly well-formed traffic: fill, schedule, leave the running task, erase
	task automatic send_random;
		int            k;
		rsq_pkg::req_t r;
		bit [7:0]      tid;
		k = $urandom_range(99);
		tid = pick_tid();
		if (k < ((act_q.size() > 40) ? 15 : 35)) r = rsq_pkg::REQ_ENQ;
		else if (k < 50) r = rsq_pkg::REQ_ERASE;
		else if (k < 80) r = rsq_pkg::REQ_SCHED;
		else begin
			r = rsq_pkg::REQ_LEAVE;
			if (cur_present && $urandom_range(99) < 80) tid = cur_tid;
		end
		send_req(r, tid, 1'($urandom), 1'($urandom), 1'($urandom), pick_elapsed(),
			($urandom_range(99) < 10), ($urandom_range(99) < 85));
	endtask

	// result beats: in order, field by field
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				sched_result_t e;
				e = pending_results[0];
				pending_results.delete(0);
				if (picked_task !== e.picked) begin
					$error("picked_task exp %0d got %0d", e.picked, picked_task);
					errors++;
				end
				if (picked_valid !== e.pvalid) begin
					$error("picked_valid exp %0d got %0d", e.pvalid, picked_valid);
					errors++;
				end
				if (yield_on_idle !== e.yield) begin
					$error("yield_on_idle exp %0d got %0d", e.yield, yield_on_idle);
					errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
				if (current_valid !== e.curv) begin
					$error("current_valid exp %0d got %0d", e.curv, current_valid);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, long hold-offs on request
	initial begin
		out_ready <= 1'b0;
		hold_cnt = 0;
		stall_done_n = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_req_n != stall_done_n) begin
				stall_done_n = stall_req_n;
				hold_cnt = HOLD_LEN;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (no_idle) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(99) >= 10);
		end
	end

	task automatic test_enqueue_extremes;
		send_req(rsq_pkg::REQ_ENQ, 8'd255, 1'b0, 1'b1, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_ENQ, 8'd0, 1'b1, 1'b1, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_ENQ, 8'd5, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_ERASE, 8'd77, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_ERASE, 8'd255, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_ERASE, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_schedule_paths;
		// agent boost yields with work pending
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b1, 1'b1);
		// failed commit puts the task back at the front
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b0);
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		// charge part of the slice, then commit fails for the running task
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd100, 1'b0, 1'b0);
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		// slice expiry sends the task to the expired deque, then deques swap
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'hFFFFFF, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_LEAVE, 8'd200, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_LEAVE, cur_tid, 1'b1, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_LEAVE, cur_tid, 1'b0, 1'b0, 1'b1, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		// nothing to pick, under agent boost
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b1, 1'b1);
		drain();
	endtask

	task automatic test_queue_full;
		for (int i = 0; i < QDEPTH + 2; i++)
			send_req(rsq_pkg::REQ_ENQ, 8'(i), 1'(i & 1), 1'b1, 1'b0, 24'd0, 1'b0, 1'b1);
		// erase deep in a full deque, refill it, then a failed commit puts the popped task back
		send_req(rsq_pkg::REQ_ERASE, 8'd10, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_ENQ, 8'd99, 1'b1, 1'b0, 1'b0, 24'd0, 1'b0, 1'b1);
		send_req(rsq_pkg::REQ_SCHED, 8'd0, 1'b0, 1'b0, 1'b0, 24'd0, 1'b0, 1'b0);
		drain();
	endtask

	task automatic test_backpressure;
		stall_req_n++;
		for (int i = 0; i < 40; i++) send_random();
		drain();
	endtask

	task automatic test_random(int n);
		bit [23:0] slices[4];
		slices = '{24'd1, 24'hFFFFFF, 24'd10000, 24'd500};
		for (int ph = 0; ph < 5; ph++) begin
			write_slice((ph < 4) ? slices[ph] : 24'($urandom_range(1, 30000)));
			no_idle = (ph == 2);
			for (int i = 0; i < n / 5; i++) send_random();
			drain();
		end
		no_idle = 0;
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		no_idle = 0;
		stall_req_n = 0;
		slice_ticks = rsq_pkg::SLICE_RESET;
		cur_present = 0;
		cur_tid = 0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		in_valid      <= 1'b0;
		req_type      <= rsq_pkg::REQ_ENQ;
		task_id       <= '0;
		boost         <= 1'b0;
		reset_slice   <= 1'b0;
		goes_blocked  <= 1'b0;
		elapsed_ticks <= '0;
		agent_boost   <= 1'b0;
		commit_ok     <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_enqueue_extremes();
		test_schedule_paths();
		test_queue_full();
		test_backpressure();
		test_random(1100);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
